// ===== design/pfra_pkg.sv =====
// shared types, codes and constants of the page frame range allocator
package pfra_pkg;

  localparam int FRAME_BYTES_DEFAULT    = 4096;
  localparam int RANGE_CAPACITY_DEFAULT = 16;
  localparam int MAX_CAPACITY           = 64;
  localparam int IDX_W                  = $clog2(MAX_CAPACITY);
  localparam int LEFT_W                 = $clog2(MAX_CAPACITY + 1);
  localparam int CNT_W                  = 53;
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_ALLOC = 2'd2;

  localparam logic [3:0] KIND_USABLE = 4'd0;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_USABLE = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_FULL       = 3'd3,
    ST_NO_PAGES   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_CHECK,
    S_COUNT,
    S_SCAN,
    S_EMIT
  } state_t;

  // scan token walking down the range cells
  typedef struct packed {
    logic              live;
    logic              found;
    logic [LEFT_W-1:0] left;
    logic [63:0]       addr;
  } tok_t;

  // range write broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [63:0]      start;
    logic [63:0]      stop;
  } wr_t;

endpackage

// ===== design/pfra_req_if.sv =====
// request channel of the page frame range allocator
interface pfra_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] region_base;
  logic [63:0] region_length;
  logic [3:0]  region_kind;

  modport source (output valid, output req_type, output region_base,
                  output region_length, output region_kind, input ready);
  modport sink (input valid, input req_type, input region_base,
                input region_length, input region_kind, output ready);
endinterface

// ===== design/pfra_res_if.sv =====
// result channel of the page frame range allocator
interface pfra_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] page_address;
  logic [4:0]  range_total;
  logic [52:0] covered_pages;
  logic [52:0] spare_pages;
  logic [52:0] granted_pages;
  logic [52:0] allocation_total;

  modport source (output valid, output status, output page_address,
                  output range_total, output covered_pages, output spare_pages,
                  output granted_pages, output allocation_total, input ready);
  modport sink (input valid, input status, input page_address,
                input range_total, input covered_pages, input spare_pages,
                input granted_pages, input allocation_total, output ready);
endinterface

// ===== design/pfra_cell.sv =====
// one range cell: holds a next page and end address, claims the scan token
module pfra_cell #(
  parameter int FRAME_BYTES = pfra_pkg::FRAME_BYTES_DEFAULT,
  parameter int INDEX       = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  pfra_pkg::tok_t tok_in,
  input  pfra_pkg::wr_t  wr,
  output pfra_pkg::tok_t tok_out
);

  logic [63:0]    next_page;
  logic [63:0]    end_addr;
  logic           claim;
  pfra_pkg::tok_t tok_next;

  // only cells below the fill count see a nonzero left count
  assign claim = tok_in.live && !tok_in.found && (tok_in.left != '0) &&
                 (next_page < end_addr);

  always_comb begin
    tok_next = tok_in;
    if (tok_in.left != '0) begin
      tok_next.left = tok_in.left - 1'b1;
    end
    if (claim) begin
      tok_next.found = 1'b1;
      tok_next.addr  = next_page;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == pfra_pkg::IDX_W'(INDEX))) begin
      next_page <= wr.start;
      end_addr  <= wr.stop;
    end else if (claim) begin
      next_page <= next_page + 64'(FRAME_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== design/pfra_ctrl.sv =====
// request sequencer: alignment, range fill, counters and result register
module pfra_ctrl #(
  parameter int FRAME_BYTES    = pfra_pkg::FRAME_BYTES_DEFAULT,
  parameter int RANGE_CAPACITY = pfra_pkg::RANGE_CAPACITY_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  pfra_req_if.sink       req,
  pfra_res_if.source     res,
  output pfra_pkg::tok_t tok_first,
  input  pfra_pkg::tok_t tok_last,
  output pfra_pkg::wr_t  wr
);

  localparam int PAGE_BITS = $clog2(FRAME_BYTES);
  localparam logic [63:0] PAGE_MASK = 64'(FRAME_BYTES - 1);
  localparam int UW = $clog2(RANGE_CAPACITY + 1);
  localparam int CW = pfra_pkg::CNT_W;

  pfra_pkg::state_t  state, state_next;
  pfra_pkg::status_t status_q;
  logic [UW-1:0]     used;
  logic [63:0]       base_q, len_q, start_q, stop_q, pages_q, addr_q;
  logic [CW-1:0]     pages_total, pages_free, pages_allocated, alloc_done;
  logic [64:0]       up_sum, end_sum;
  logic [63:0]       start_c, stop_c;
  logic              has_room, non_empty, emit;

  function automatic logic [CW-1:0] cnt_add(logic [CW-1:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {(65 - CW)'(0), a} + {1'b0, b};
    return (s > {(65 - CW)'(0), pfra_pkg::CNT_MAX}) ? pfra_pkg::CNT_MAX : s[CW-1:0];
  endfunction

  // page alignment, saturating at the top of the address space
  assign up_sum  = {1'b0, base_q} + {1'b0, PAGE_MASK};
  assign end_sum = {1'b0, base_q} + {1'b0, len_q};
  assign start_c = up_sum[64] ? '1 : (up_sum[63:0] & ~PAGE_MASK);
  assign stop_c  = (end_sum[64] ? '1 : end_sum[63:0]) & ~PAGE_MASK;

  assign has_room  = used < UW'(RANGE_CAPACITY);
  assign non_empty = stop_q > start_q;
  assign emit      = (state == pfra_pkg::S_EMIT) && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfra_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    tok_first  = '0;
    wr         = '0;
    case (state)
      pfra_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          case (req.req_type)
            pfra_pkg::REQ_ADD: begin
              state_next = (req.region_kind != pfra_pkg::KIND_USABLE) ?
                           pfra_pkg::S_EMIT : pfra_pkg::S_ALIGN;
            end
            pfra_pkg::REQ_ALLOC: begin
              tok_first.live = 1'b1;
              tok_first.left = pfra_pkg::LEFT_W'(used);
              state_next     = pfra_pkg::S_SCAN;
            end
            default: state_next = pfra_pkg::S_EMIT;
          endcase
        end
      end
      pfra_pkg::S_ALIGN: state_next = pfra_pkg::S_CHECK;
      pfra_pkg::S_CHECK: begin
        if (non_empty && has_room) begin
          wr.en      = 1'b1;
          wr.idx     = pfra_pkg::IDX_W'(used);
          wr.start   = start_q;
          wr.stop    = stop_q;
          state_next = pfra_pkg::S_COUNT;
        end else begin
          state_next = pfra_pkg::S_EMIT;
        end
      end
      pfra_pkg::S_COUNT: state_next = pfra_pkg::S_EMIT;
      pfra_pkg::S_SCAN: begin
        if (tok_last.live) begin
          state_next = pfra_pkg::S_EMIT;
        end
      end
      pfra_pkg::S_EMIT: begin
        if (!res.valid || res.ready) begin
          state_next = pfra_pkg::S_IDLE;
        end
      end
      default: state_next = pfra_pkg::S_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      used            <= '0;
      pages_total     <= '0;
      pages_free      <= '0;
      pages_allocated <= '0;
      alloc_done      <= '0;
    end else begin
      case (state)
        pfra_pkg::S_IDLE: begin
          if (req.valid && (req.req_type == pfra_pkg::REQ_CLEAR)) begin
            used            <= '0;
            pages_total     <= '0;
            pages_free      <= '0;
            pages_allocated <= '0;
            alloc_done      <= '0;
          end
        end
        pfra_pkg::S_CHECK: begin
          if (wr.en) begin
            used <= used + 1'b1;
          end
        end
        pfra_pkg::S_COUNT: begin
          pages_total <= cnt_add(pages_total, pages_q);
          pages_free  <= cnt_add(pages_free, pages_q);
        end
        pfra_pkg::S_SCAN: begin
          if (tok_last.live && tok_last.found) begin
            if (pages_free != '0) begin
              pages_free <= pages_free - 1'b1;
            end
            pages_allocated <= cnt_add(pages_allocated, 64'd1);
            alloc_done      <= cnt_add(alloc_done, 64'd1);
          end
        end
        default: ;
      endcase
    end
  end

  // request payload and per-request status
  always_ff @(posedge clk) begin
    case (state)
      pfra_pkg::S_IDLE: begin
        base_q   <= req.region_base;
        len_q    <= req.region_length;
        addr_q   <= '0;
        status_q <= pfra_pkg::ST_OK;
        if ((req.req_type == pfra_pkg::REQ_ADD) &&
            (req.region_kind != pfra_pkg::KIND_USABLE)) begin
          status_q <= pfra_pkg::ST_NOT_USABLE;
        end
      end
      pfra_pkg::S_ALIGN: begin
        start_q <= start_c;
        stop_q  <= stop_c;
      end
      pfra_pkg::S_CHECK: begin
        pages_q <= (stop_q - start_q) >> PAGE_BITS;
        if (!non_empty) begin
          status_q <= pfra_pkg::ST_EMPTY;
        end else if (!has_room) begin
          status_q <= pfra_pkg::ST_FULL;
        end
      end
      pfra_pkg::S_SCAN: begin
        if (tok_last.live) begin
          if (tok_last.found) begin
            addr_q <= tok_last.addr;
          end else begin
            status_q <= pfra_pkg::ST_NO_PAGES;
          end
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.status           <= status_q;
      res.page_address     <= addr_q;
      res.range_total      <= 5'(used);
      res.covered_pages    <= pages_total;
      res.spare_pages      <= pages_free;
      res.granted_pages    <= pages_allocated;
      res.allocation_total <= alloc_done;
    end
  end

  a_tok_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_last.live |-> state == pfra_pkg::S_SCAN)
    else $error("scan token returned outside a scan");

  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    pages_free <= pages_total)
    else $error("free pages exceed total pages");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(RANGE_CAPACITY))
    else $error("range count beyond capacity");

  a_write_grows_table: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> used == $past(used) + 1'b1)
    else $error("range write did not advance the fill count");

endmodule

// ===== design/page_frame_range_allocator.sv =====
// clear, unused codes and unusable regions go from idle straight to the result state
// add: align, check, count unless empty or full; allocate: token steps one cell per cycle
// one request in flight; the next is taken once the result is in the output register
// throughput set by the cell chain for allocate, by the alignment sequence for add
// reset (synchronous, active high) empties the range table and zeroes all counters
// range cell contents are not cleared; only cells below the fill count are ever read
module page_frame_range_allocator #(
  parameter int FRAME_BYTES    = pfra_pkg::FRAME_BYTES_DEFAULT,
  parameter int RANGE_CAPACITY = pfra_pkg::RANGE_CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  pfra_req_if.sink   req,
  pfra_res_if.source res
);

  pfra_pkg::tok_t tok [RANGE_CAPACITY+1];
  pfra_pkg::wr_t  wr;

  pfra_ctrl #(
    .FRAME_BYTES    (FRAME_BYTES),
    .RANGE_CAPACITY (RANGE_CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .tok_first (tok[0]),
    .tok_last  (tok[RANGE_CAPACITY]),
    .wr        (wr)
  );

  for (genvar i = 0; i < RANGE_CAPACITY; i++) begin : g_cell
    pfra_cell #(
      .FRAME_BYTES (FRAME_BYTES),
      .INDEX       (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .wr      (wr),
      .tok_out (tok[i+1])
    );
  end

endmodule
